>>> src/wsdf_pkg.sv
// Shared constants for the WebSocket frame deframer: length codes, opcodes and event kinds.
package wsdf_pkg;

	localparam logic [6:0] LEN_64BIT = 7'd127;
	localparam logic [6:0] LEN_16BIT = 7'd126;

	localparam logic [3:0] OP_BINARY = 4'h2;
	localparam logic [3:0] OP_CLOSE  = 4'h8;

	localparam logic [1:0] EV_DATA  = 2'd0;
	localparam logic [1:0] EV_EMPTY = 2'd1;
	localparam logic [1:0] EV_CLOSE = 2'd2;
	localparam logic [1:0] EV_ERROR = 2'd3;

endpackage

>>> src/websocket_frame_deframer.sv
// Top level of the WebSocket frame deframer: header parsing, unmasking and event generation.
//
// The input channel (in_valid, in_ready, in_byte) takes one byte of the client-to-server
// stream per request. The output channel (out_valid, out_ready and the four result fields)
// gives at most one result per input byte: an unmasked binary payload byte, an empty-message
// event, a close event or an unsupported-opcode error event.
// Each accepted byte is held in an input register and is then parsed by the
// frame state logic, whose result is written into an output register. One byte
// per cycle is sustained whenever the receiver takes results as they come.
// Header bytes, extended length bytes, key bytes and the payload of close or other
// frames produce no result; only the final byte of such a frame carries its event.
// After a close or error event the block discards every further byte until reset.
// The asynchronous reset empties both registers and returns the parser to the first
// header byte. When the receiver stalls, the output register holds its result and the
// input register holds one further byte; in_ready falls only when both are full.
module websocket_frame_deframer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic [1:0] event_kind,
	output logic       last_of_message,
	output logic       fin_flag
);

	localparam logic [2:0] PH_HDR0    = 3'd0;
	localparam logic [2:0] PH_HDR1    = 3'd1;
	localparam logic [2:0] PH_EXTLEN  = 3'd2;
	localparam logic [2:0] PH_KEY     = 3'd3;
	localparam logic [2:0] PH_PAYLOAD = 3'd4;
	localparam logic [2:0] PH_HALTED  = 3'd5;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        adv;

	logic [2:0]  phase_q, phase_d;
	logic        fin_q, fin_d;
	logic [3:0]  opcode_q, opcode_d;
	logic        masked_q, masked_d;
	logic [2:0]  hbc_q, hbc_d;
	logic        ext64_q, ext64_d;
	logic [63:0] rem_q, rem_d;
	logic [31:0] key_q, key_d;
	logic [1:0]  kpos_q, kpos_d;

	logic        res_v;
	logic [7:0]  res_byte;
	logic [1:0]  res_ev;
	logic        res_last;

	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic [1:0]  event_kind_q;
	logic        last_q;
	logic        fin_out_q;

	logic [2:0]  ef_phase;
	logic [1:0]  ef_ev;
	logic [6:0]  len7;
	logic [63:0] rem_shift;
	logic [63:0] rem_dec;
	logic [7:0]  key_byte;
	logic        ext_done;

	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	always_comb begin
		if (opcode_q == wsdf_pkg::OP_BINARY) begin
			ef_phase = PH_HDR0;
			ef_ev    = wsdf_pkg::EV_EMPTY;
		end else if (opcode_q == wsdf_pkg::OP_CLOSE) begin
			ef_phase = PH_HALTED;
			ef_ev    = wsdf_pkg::EV_CLOSE;
		end else begin
			ef_phase = PH_HALTED;
			ef_ev    = wsdf_pkg::EV_ERROR;
		end
	end

	assign len7      = byte_s1[6:0];
	assign rem_shift = {rem_q[55:0], byte_s1};
	assign rem_dec   = rem_q - 64'd1;
	assign ext_done  = ext64_q ? (hbc_q == 3'd7) : (hbc_q != 3'd0);

	always_comb begin
		case (kpos_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	always_comb begin
		phase_d  = phase_q;
		fin_d    = fin_q;
		opcode_d = opcode_q;
		masked_d = masked_q;
		hbc_d    = hbc_q;
		ext64_d  = ext64_q;
		rem_d    = rem_q;
		key_d    = key_q;
		kpos_d   = kpos_q;
		res_v    = 1'b0;
		res_byte = 8'd0;
		res_ev   = wsdf_pkg::EV_DATA;
		res_last = 1'b0;
		unique case (phase_q)
			PH_HDR0: begin
				fin_d    = byte_s1[7];
				opcode_d = byte_s1[3:0];
				phase_d  = PH_HDR1;
			end
			PH_HDR1: begin
				masked_d = byte_s1[7];
				hbc_d    = 3'd0;
				if (len7 == wsdf_pkg::LEN_64BIT || len7 == wsdf_pkg::LEN_16BIT) begin
					rem_d   = 64'd0;
					ext64_d = (len7 == wsdf_pkg::LEN_64BIT);
					phase_d = PH_EXTLEN;
				end else begin
					rem_d = {57'd0, len7};
					if (byte_s1[7]) begin
						key_d   = 32'd0;
						phase_d = PH_KEY;
					end else begin
						kpos_d = 2'd0;
						if (len7 == 7'd0) begin
							phase_d  = ef_phase;
							res_v    = 1'b1;
							res_ev   = ef_ev;
							res_last = 1'b1;
						end else begin
							phase_d = PH_PAYLOAD;
						end
					end
				end
			end
			PH_EXTLEN: begin
				rem_d = rem_shift;
				if (ext_done) begin
					hbc_d = 3'd0;
					if (masked_q) begin
						key_d   = 32'd0;
						phase_d = PH_KEY;
					end else begin
						kpos_d = 2'd0;
						if (rem_shift == 64'd0) begin
							phase_d  = ef_phase;
							res_v    = 1'b1;
							res_ev   = ef_ev;
							res_last = 1'b1;
						end else begin
							phase_d = PH_PAYLOAD;
						end
					end
				end else begin
					hbc_d = hbc_q + 3'd1;
				end
			end
			PH_KEY: begin
				key_d = {key_q[23:0], byte_s1};
				if (hbc_q >= 3'd3) begin
					hbc_d  = 3'd0;
					kpos_d = 2'd0;
					if (rem_q == 64'd0) begin
						phase_d  = ef_phase;
						res_v    = 1'b1;
						res_ev   = ef_ev;
						res_last = 1'b1;
					end else begin
						phase_d = PH_PAYLOAD;
					end
				end else begin
					hbc_d = hbc_q + 3'd1;
				end
			end
			PH_PAYLOAD: begin
				rem_d = rem_dec;
				if (opcode_q == wsdf_pkg::OP_BINARY) begin
					kpos_d   = kpos_q + 2'd1;
					res_v    = 1'b1;
					res_byte = masked_q ? (byte_s1 ^ key_byte) : byte_s1;
					res_ev   = wsdf_pkg::EV_DATA;
					res_last = (rem_dec == 64'd0);
					if (rem_dec == 64'd0) begin
						phase_d = PH_HDR0;
					end
				end else if (rem_dec == 64'd0) begin
					phase_d  = PH_HALTED;
					res_v    = 1'b1;
					res_ev   = ef_ev;
					res_last = 1'b1;
				end
			end
			default: begin
				phase_d = phase_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR0;
			fin_q    <= 1'b0;
			opcode_q <= 4'd0;
			masked_q <= 1'b0;
			hbc_q    <= 3'd0;
			ext64_q  <= 1'b0;
			rem_q    <= 64'd0;
			key_q    <= 32'd0;
			kpos_q   <= 2'd0;
		end else if (adv) begin
			phase_q  <= phase_d;
			fin_q    <= fin_d;
			opcode_q <= opcode_d;
			masked_q <= masked_d;
			hbc_q    <= hbc_d;
			ext64_q  <= ext64_d;
			rem_q    <= rem_d;
			key_q    <= key_d;
			kpos_q   <= kpos_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= res_v;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_v) begin
			out_byte_q   <= res_byte;
			event_kind_q <= res_ev;
			last_q       <= res_last;
			fin_out_q    <= fin_d;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_byte        = out_byte_q;
	assign event_kind      = event_kind_q;
	assign last_of_message = last_q;
	assign fin_flag        = fin_out_q;

endmodule

>>> src/wsdf_checker.sv
// Port-level checker for the WebSocket frame deframer and its bind to the top level.
module wsdf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic [1:0] event_kind,
	input logic       last_of_message
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("A result request was withdrawn before it was taken.");

	a_event_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind != wsdf_pkg::EV_DATA |-> out_byte == 8'd0)
		else $error("An event result carries a non-zero byte.");

	a_event_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind != wsdf_pkg::EV_DATA |-> last_of_message)
		else $error("An event result does not end its frame.");

	a_halt_after_close: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready
		&& (event_kind == wsdf_pkg::EV_CLOSE || event_kind == wsdf_pkg::EV_ERROR)
		|=> !out_valid)
		else $error("A result followed a close or error event.");

endmodule

bind websocket_frame_deframer wsdf_checker u_wsdf_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.out_byte        (out_byte),
	.event_kind      (event_kind),
	.last_of_message (last_of_message)
);
